@@ sv/irigb_pkg.sv @@
// ----------------------------------------------------------------------------
// irigb_pkg
// Shared types, tables and the weighted BCD encoder of the IRIG-B frame
// builder.
// ----------------------------------------------------------------------------
package irigb_pkg;

    localparam int SEG_COUNT  = 10;
    localparam int SEG_SYMS   = 10;
    localparam int FRAME_SYMS = SEG_COUNT * SEG_SYMS;
    localparam int WMAX       = 10;

    localparam logic [3:0] LAST_SEG   = 4'd9;
    localparam logic [9:0] MARK_FIRST = 10'd513;
    localparam logic [9:0] MARK_OTHER = 10'd512;

    typedef logic [FRAME_SYMS-1:0] t_frame;
    typedef logic [SEG_SYMS-1:0]   t_seg;
    typedef logic [7:0]            t_wtab [WMAX];
    typedef logic [6:0]            t_ptab [WMAX];

    typedef struct packed {
        logic [WMAX-1:0] bits;
        logic [8:0]      rem;
    } t_greedy;

    // weights, heaviest first; unused tail entries are masked by the count
    localparam t_wtab W_SEC    = '{8'd40, 8'd20, 8'd10, 8'd8, 8'd4, 8'd2, 8'd1,
                                   8'd0, 8'd0, 8'd0};
    localparam t_wtab W_HOUR   = '{8'd20, 8'd10, 8'd8, 8'd4, 8'd2, 8'd1,
                                   8'd0, 8'd0, 8'd0, 8'd0};
    localparam t_wtab W_YEAR   = '{8'd80, 8'd40, 8'd20, 8'd10, 8'd8, 8'd4, 8'd2,
                                   8'd1, 8'd0, 8'd0};
    localparam t_wtab W_DOY_HI = '{8'd200, 8'd100, 8'd80, 8'd40, 8'd20,
                                   8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    localparam t_wtab W_DOY_LO = '{8'd10, 8'd8, 8'd4, 8'd2, 8'd1,
                                   8'd0, 8'd0, 8'd0, 8'd0, 8'd0};

    // symbol positions matching the weights above
    localparam t_ptab P_SEC    = '{7'd8, 7'd7, 7'd6, 7'd4, 7'd3, 7'd2, 7'd1,
                                   7'd0, 7'd0, 7'd0};
    localparam t_ptab P_MIN    = '{7'd17, 7'd16, 7'd15, 7'd13, 7'd12, 7'd11, 7'd10,
                                   7'd0, 7'd0, 7'd0};
    localparam t_ptab P_HOUR   = '{7'd26, 7'd25, 7'd23, 7'd22, 7'd21, 7'd20,
                                   7'd0, 7'd0, 7'd0, 7'd0};
    localparam t_ptab P_YEAR   = '{7'd58, 7'd57, 7'd56, 7'd55, 7'd53, 7'd52, 7'd51,
                                   7'd50, 7'd0, 7'd0};
    localparam t_ptab P_DOY_HI = '{7'd41, 7'd40, 7'd38, 7'd37, 7'd36,
                                   7'd0, 7'd0, 7'd0, 7'd0, 7'd0};
    localparam t_ptab P_DOY_LO = '{7'd35, 7'd33, 7'd32, 7'd31, 7'd30,
                                   7'd0, 7'd0, 7'd0, 7'd0, 7'd0};

    localparam int N_SEC    = 7;
    localparam int N_HOUR   = 6;
    localparam int N_YEAR   = 8;
    localparam int N_DOY_HI = 5;
    localparam int N_DOY_LO = 5;

    // days before the given month; month 0 sums none, above 12 sums all
    typedef logic [8:0] t_mtab [16];
    localparam t_mtab MOFF_COMMON = '{9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120,
        9'd151, 9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd365, 9'd365};
    localparam t_mtab MOFF_LEAP   = '{9'd0, 9'd0, 9'd31, 9'd60, 9'd91, 9'd121,
        9'd152, 9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366, 9'd366, 9'd366};

    // greedy weighted subtraction; every weight that fits, the lightest too,
    // sets its bit and is taken off the remainder
    function automatic t_greedy greedy(input logic [8:0] value, input t_wtab w,
                                       input int n);
        t_greedy    r;
        logic [8:0] v;
        v      = value;
        r.bits = '0;
        for (int i = 0; i < WMAX; i++) begin
            if (i < n && v >= {1'b0, w[i]}) begin
                r.bits[i] = 1'b1;
                v         = v - {1'b0, w[i]};
            end
        end
        r.rem = v;
        return r;
    endfunction

endpackage

@@ sv/irig_b_frame_builder.sv @@
// ----------------------------------------------------------------------------
// irig_b_frame_builder
// Builds one 100-symbol IRIG-B frame per time item and sends it out as ten
// 10-symbol segments.
// ----------------------------------------------------------------------------
// Each accepted time item yields ten output items, segments 0 to 9 in order,
// one per cycle while the sink is ready; the output serialiser sets the
// sustained rate. An accepted input item passes through three compute stages
// and the serialiser load before its first segment goes out. Stage 1 forms
// the range flag and the day of year from a cumulative month-length table
// (leap table when year mod 4 is zero); stage 2 encodes seconds, minutes,
// hours, year and the heavy day-of-year weights as BCD by greedy
// subtraction; stage 3 finishes the light day-of-year weights.
// The pipeline keeps taking items while the serialiser is busy until it
// fills, then back-pressures. Control-function and straight-binary-seconds
// symbols are always zero; out-of-range fields set range_error on every
// segment and are still encoded by the same rule.
module irig_b_frame_builder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [4:0] i_hour,
    input  logic [5:0] i_minute,
    input  logic [5:0] i_second,
    input  logic [4:0] i_day_of_month,
    input  logic [3:0] i_month,
    input  logic [6:0] i_year,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_segment_index,
    output logic [9:0] o_data_bits,
    output logic [9:0] o_marker_bits,
    output logic       o_last_segment,
    output logic       o_range_error
);
    import irigb_pkg::*;

    // ---- handshake / stall chain -----------------------------------------
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_ser_valid;
    logic s1_free, s2_free, s3_free, ser_load, ser_adv, ser_done;

    logic [3:0] r_seg;

    assign ser_adv  = r_ser_valid && i_out_ready;
    assign ser_done = ser_adv && (r_seg == LAST_SEG);
    assign ser_load = r_s3_valid && (!r_ser_valid || ser_done);
    assign s3_free  = !r_s3_valid || ser_load;
    assign s2_free  = !r_s2_valid || s3_free;
    assign s1_free  = !r_s1_valid || s2_free;
    assign o_in_ready = s1_free;

    // ---- stage 1: range check and day of year ----------------------------
    logic       r_s1_err;
    logic [8:0] r_s1_doy;
    logic [5:0] r_s1_sec, r_s1_min;
    logic [4:0] r_s1_hour;
    logic [6:0] r_s1_year;
    logic       n_s1_err, n_leap;
    logic [8:0] n_s1_doy;

    always_comb begin
        n_leap   = (i_year[1:0] == 2'd0);
        n_s1_err = (i_hour > 5'd23) || (i_minute > 6'd59) || (i_second > 6'd59) ||
                   (i_day_of_month == 5'd0) || (i_month == 4'd0) ||
                   (i_month > 4'd12) || (i_year > 7'd99);
        n_s1_doy = {4'd0, i_day_of_month} +
                   (n_leap ? MOFF_LEAP[i_month] : MOFF_COMMON[i_month]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_in_valid) begin
            r_s1_err  <= n_s1_err;
            r_s1_doy  <= n_s1_doy;
            r_s1_sec  <= i_second;
            r_s1_min  <= i_minute;
            r_s1_hour <= i_hour;
            r_s1_year <= i_year;
        end
    end

    // ---- stage 2: BCD of most fields, heavy day-of-year weights -----------
    logic       r_s2_err;
    t_frame     r_s2_frame;
    logic [4:0] r_s2_doy_rem;
    t_frame     n_s2_frame;
    t_greedy    g_sec, g_min, g_hour, g_year, g_doy_hi;

    always_comb begin
        g_sec    = greedy({3'd0, r_s1_sec}, W_SEC, N_SEC);
        g_min    = greedy({3'd0, r_s1_min}, W_SEC, N_SEC);
        g_hour   = greedy({4'd0, r_s1_hour}, W_HOUR, N_HOUR);
        g_year   = greedy({2'd0, r_s1_year}, W_YEAR, N_YEAR);
        g_doy_hi = greedy(r_s1_doy, W_DOY_HI, N_DOY_HI);
        n_s2_frame = '0;
        for (int i = 0; i < N_SEC; i++) begin
            n_s2_frame[P_SEC[i]] = g_sec.bits[i];
            n_s2_frame[P_MIN[i]] = g_min.bits[i];
        end
        for (int i = 0; i < N_HOUR; i++) begin
            n_s2_frame[P_HOUR[i]] = g_hour.bits[i];
        end
        for (int i = 0; i < N_YEAR; i++) begin
            n_s2_frame[P_YEAR[i]] = g_year.bits[i];
        end
        for (int i = 0; i < N_DOY_HI; i++) begin
            n_s2_frame[P_DOY_HI[i]] = g_doy_hi.bits[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && r_s1_valid) begin
            r_s2_err     <= r_s1_err;
            r_s2_frame   <= n_s2_frame;
            r_s2_doy_rem <= g_doy_hi.rem[4:0];  // below 20 after the 20 weight
        end
    end

    // ---- stage 3: light day-of-year weights ------------------------------
    logic    r_s3_err;
    t_frame  r_s3_frame;
    t_frame  n_s3_frame;
    t_greedy g_doy_lo;

    always_comb begin
        g_doy_lo   = greedy({4'd0, r_s2_doy_rem}, W_DOY_LO, N_DOY_LO);
        n_s3_frame = r_s2_frame;
        for (int i = 0; i < N_DOY_LO; i++) begin
            n_s3_frame[P_DOY_LO[i]] = g_doy_lo.bits[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (s3_free) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_free && r_s2_valid) begin
            r_s3_err   <= r_s2_err;
            r_s3_frame <= n_s3_frame;
        end
    end

    // ---- output serialiser: one segment per accepted output item ----------
    t_seg r_ser_seg [SEG_COUNT];
    logic r_ser_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_valid <= 1'b0;
            r_seg       <= '0;
        end else if (ser_load) begin
            r_ser_valid <= 1'b1;
            r_seg       <= '0;
        end else if (ser_adv) begin
            if (r_seg == LAST_SEG) begin
                r_ser_valid <= 1'b0;
                r_seg       <= '0;
            end else begin
                r_seg <= r_seg + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_load) begin
            r_ser_err <= r_s3_err;
            for (int s = 0; s < SEG_COUNT; s++) begin
                r_ser_seg[s] <= r_s3_frame[s*SEG_SYMS +: SEG_SYMS];
            end
        end
    end

    assign o_out_valid     = r_ser_valid;
    assign o_segment_index = r_seg;
    assign o_data_bits     = r_ser_seg[r_seg];
    assign o_marker_bits   = (r_seg == 4'd0) ? MARK_FIRST : MARK_OTHER;
    assign o_last_segment  = (r_seg == LAST_SEG);
    assign o_range_error   = r_ser_err;

    // ---- assertions --------------------------------------------------------
    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_segment_index <= LAST_SEG))
        else $error("segment index beyond last segment");

    a_seg_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_segment) |=>
            (o_out_valid && (o_segment_index == $past(o_segment_index) + 4'd1)))
        else $error("segment sequence broken mid-frame");

    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> (o_segment_index == 4'd0))
        else $error("frame did not start at segment zero");

    a_s3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_valid && !ser_load) |=> r_s3_valid)
        else $error("stage 3 item dropped");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !r_s1_valid && !r_s2_valid && !r_s3_valid))
        else $error("pipeline not empty after reset");

endmodule
